// ----- hw/rtl/hls_pkg.sv -----
// Shared constants and the hash_rank helper function for the HyperLogLog sketch.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package hls_pkg;
    localparam int BUCKET_BITS = 4;
    localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
    localparam int HASH_W      = 64;
    localparam int RANK_W      = 6;
    localparam int RANK_CAP    = HASH_W - BUCKET_BITS + 1;
    localparam int ALPHA_W     = 16;
    localparam int KIND_W      = 2;
    localparam int MBKT_W      = 4;
    localparam int EST_W       = 40;
    localparam int SUM_W       = HASH_W + BUCKET_BITS + 1;
    localparam int NUM_W       = ALPHA_W + 2 * BUCKET_BITS + 48;
    localparam int ZERO_W      = BUCKET_BITS + 1;
    localparam int EXP_W       = $clog2(BUCKET_BITS + 1);
    localparam int FRAC_W      = 30;
    localparam int LOG_W       = FRAC_W + EXP_W;
    localparam int CMP_W       = SUM_W + 3;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd44285;
    localparam logic [29:0]        LN2_Q30     = 30'd744261118;

    localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MERGE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ESTIMATE = 2'd2;

    // Leading-zero count of the hash bits below the index, plus one.
    // An all-zero remainder gives exactly the cap.
    function automatic logic [RANK_W-1:0] hash_rank(input logic [HASH_W-1:0] h);
        logic [RANK_W-1:0] r;
        r = RANK_W'(RANK_CAP);
        for (int i = 0; i < HASH_W - BUCKET_BITS; i++) begin
            if (h[i]) begin
                r = RANK_W'(HASH_W - BUCKET_BITS - i);
            end
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/hls_if.sv -----
// Valid/ready channel interfaces for sketch items and estimate results.
// Depends on hls_pkg for field widths.
`default_nettype none
interface hls_item_if;
    logic                             valid;
    logic                             ready;
    logic [hls_pkg::KIND_W-1:0]       kind;
    logic [hls_pkg::HASH_W-1:0]       hash_value;
    logic [hls_pkg::MBKT_W-1:0]       merge_bucket;
    logic [hls_pkg::RANK_W-1:0]       merge_rank;
    modport source (output valid, kind, hash_value, merge_bucket, merge_rank, input ready);
    modport sink   (input valid, kind, hash_value, merge_bucket, merge_rank, output ready);
endinterface

interface hls_result_if;
    logic                        valid;
    logic                        ready;
    logic [hls_pkg::EST_W-1:0]   estimate;
    logic                        small_range_used;
    modport source (output valid, estimate, small_range_used, input ready);
    modport sink   (input valid, estimate, small_range_used, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/hls_divider.sv -----
// Restoring divider, one quotient bit per cycle, for the raw estimate.
// Depends on hls_pkg for operand widths.
`default_nettype none
module hls_divider (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [hls_pkg::NUM_W-1:0]   i_num,
    input  wire logic [hls_pkg::SUM_W-1:0]   i_den,
    output logic                             o_done,
    output logic [hls_pkg::NUM_W-1:0]        o_quot
);
    localparam int CNT_W = $clog2(hls_pkg::NUM_W + 1);

    logic                        r_busy;
    logic [CNT_W-1:0]            r_cnt;
    logic [hls_pkg::NUM_W-1:0]   r_num;
    logic [hls_pkg::NUM_W-1:0]   r_quot;
    logic [hls_pkg::SUM_W-1:0]   r_den;
    logic [hls_pkg::SUM_W-1:0]   r_rem;
    logic                        r_done;
    logic [hls_pkg::SUM_W:0]     trial;
    logic [hls_pkg::SUM_W:0]     diff;
    logic                        take;

    assign trial = {r_rem, r_num[hls_pkg::NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign take  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(hls_pkg::NUM_W);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quot <= '0;
            end else if (r_busy) begin
                r_num  <= r_num << 1;
                r_rem  <= take ? diff[hls_pkg::SUM_W-1:0] : trial[hls_pkg::SUM_W-1:0];
                r_quot <= {r_quot[hls_pkg::NUM_W-2:0], take};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

// ----- hw/rtl/hyperloglog_sketch.sv -----
// HyperLogLog sketch top level: rank memory, update pipeline, estimator.
// Depends on hls_pkg, hls_if and hls_divider.
//
// Usage: items arrive on i_item. Insert (hash) and merge (bucket, rank)
// beats are taken one per cycle while the estimator is idle; each reads
// its rank entry from a 16-deep synchronous memory, takes the maximum in
// the following cycle and writes it back, with the previous write
// forwarded when both touch the same entry. They give no result. An
// estimate beat blocks the input while the estimator walks the memory,
// runs the bit-serial divider, squares the log mantissa and multiplies
// by ln2. The result beat leaves on o_result from an output register;
// while it waits, insert and merge beats keep flowing, and a further
// estimate is computed but held until the register frees. Reset empties
// the memory through per-entry valid flags at once and sets alpha to its
// default; i_cfg_we writes alpha and must be used only while the block
// is idle, which the block itself does not enforce.
`default_nettype none
module hyperloglog_sketch (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [hls_pkg::ALPHA_W-1:0]   i_cfg_wdata,
    hls_item_if.sink                           i_item,
    hls_result_if.source                       o_result
);
    localparam int BB = hls_pkg::BUCKET_BITS;
    localparam int NB = hls_pkg::NUM_BUCKETS;
    localparam int RW = hls_pkg::RANK_W;

    typedef enum logic [2:0] {S_IDLE, S_WALK, S_DIV_GO, S_DIV, S_LOG, S_MUL, S_FIN} t_state;

    t_state                         r_state;
    logic [hls_pkg::ALPHA_W-1:0]    r_alpha;
    logic [RW-1:0]                  r_mem [NB];
    logic [NB-1:0]                  r_ent_vld;
    logic [RW-1:0]                  r_rd_data;
    logic                           r_rd_vld;
    logic [BB-1:0]                  rd_addr;

    logic                           r_s1_vld;
    logic [BB-1:0]                  r_s1_idx;
    logic [RW-1:0]                  r_s1_rank;
    logic                           r_fwd_vld;
    logic [BB-1:0]                  r_fwd_idx;
    logic [RW-1:0]                  r_fwd_rank;

    logic [BB:0]                    r_cnt;
    logic [hls_pkg::SUM_W-1:0]      r_sum;
    logic [hls_pkg::ZERO_W-1:0]     r_zeros;
    logic [hls_pkg::EXP_W-1:0]      r_k;
    logic [31:0]                    r_y;
    logic [hls_pkg::FRAC_W-1:0]     r_frac;
    logic [hls_pkg::LOG_W+29:0]     r_prod;
    logic                           r_small;
    logic [hls_pkg::EST_W-1:0]      r_raw;

    logic                           r_out_vld;
    logic [hls_pkg::EST_W-1:0]      r_out_est;
    logic                           r_out_small;

    logic                           accept;
    logic                           upd;
    logic [BB-1:0]                  in_idx;
    logic [RW-1:0]                  in_rank;
    logic [RW-1:0]                  cur_rank;
    logic [RW-1:0]                  new_rank;
    logic [RW-1:0]                  walk_rank;
    logic [hls_pkg::SUM_W-1:0]      term;
    logic [hls_pkg::NUM_W-1:0]      div_num;
    logic                           div_done;
    logic [hls_pkg::NUM_W-1:0]      quot;
    logic [hls_pkg::EST_W-1:0]      raw_sat;
    logic [hls_pkg::CMP_W-1:0]      cmp_lhs;
    logic [hls_pkg::CMP_W-1:0]      cmp_rhs;
    logic [hls_pkg::EXP_W-1:0]      k_calc;
    logic [63:0]                    sq;
    logic [31:0]                    y_sq;
    logic [hls_pkg::LOG_W-1:0]      ln_arg;
    logic [hls_pkg::EST_W-1:0]      small_est;

    assign accept = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);
    assign upd = accept && (i_item.kind == hls_pkg::KIND_INSERT
                            || i_item.kind == hls_pkg::KIND_MERGE);

    always_comb begin
        if (i_item.kind == hls_pkg::KIND_INSERT) begin
            in_idx  = i_item.hash_value[hls_pkg::HASH_W-1 -: BB];
            in_rank = hls_pkg::hash_rank(i_item.hash_value);
        end else begin
            in_idx  = BB'(i_item.merge_bucket);
            in_rank = (i_item.merge_rank > RW'(hls_pkg::RANK_CAP))
                      ? RW'(hls_pkg::RANK_CAP) : i_item.merge_rank;
        end
    end

    assign rd_addr = (r_state == S_WALK) ? r_cnt[BB-1:0] : in_idx;

    // The previous cycle's write is not yet visible in the read data.
    assign cur_rank = (r_fwd_vld && r_fwd_idx == r_s1_idx) ? r_fwd_rank
                    : (r_rd_vld ? r_rd_data : '0);
    assign new_rank = (r_s1_rank > cur_rank) ? r_s1_rank : cur_rank;

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (r_s1_vld) begin
            r_mem[r_s1_idx] <= new_rank;
        end
    end

    assign walk_rank = r_rd_vld ? r_rd_data : '0;
    assign term = (walk_rank == '0) ? (hls_pkg::SUM_W'(1) << hls_pkg::HASH_W)
                : (hls_pkg::SUM_W'(1) << (7'(hls_pkg::HASH_W) - 7'(walk_rank)));

    assign div_num = hls_pkg::NUM_W'(r_alpha) << (2 * BB + 48);
    assign cmp_lhs = hls_pkg::CMP_W'(r_alpha) << (BB + 49);
    assign cmp_rhs = (hls_pkg::CMP_W'(r_sum) << 2) + hls_pkg::CMP_W'(r_sum);
    assign raw_sat = (quot > hls_pkg::NUM_W'({hls_pkg::EST_W{1'b1}}))
                   ? '1 : quot[hls_pkg::EST_W-1:0];

    always_comb begin
        k_calc = '0;
        for (int i = 1; i < hls_pkg::ZERO_W; i++) begin
            if (r_zeros[i]) begin
                k_calc = hls_pkg::EXP_W'(i);
            end
        end
    end

    assign sq        = r_y * r_y;
    assign y_sq      = sq[61:30];
    assign ln_arg    = (hls_pkg::LOG_W'(BB) << hls_pkg::FRAC_W) - {r_k, r_frac};
    assign small_est = hls_pkg::EST_W'(r_prod >> (60 - BB));

    hls_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIV_GO),
        .i_num   (div_num),
        .i_den   (r_sum),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_alpha     <= hls_pkg::ALPHA_RESET;
            r_ent_vld   <= '0;
            r_rd_vld    <= 1'b0;
            r_s1_vld    <= 1'b0;
            r_fwd_vld   <= 1'b0;
            r_out_vld   <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_alpha <= i_cfg_wdata;
            end
            r_rd_vld  <= r_ent_vld[rd_addr];
            r_s1_vld  <= upd;
            r_s1_idx  <= in_idx;
            r_s1_rank <= in_rank;
            r_fwd_vld <= r_s1_vld;
            r_fwd_idx <= r_s1_idx;
            r_fwd_rank <= new_rank;
            if (r_s1_vld) begin
                r_ent_vld[r_s1_idx] <= 1'b1;
            end
            if (o_result.valid && o_result.ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_item.kind == hls_pkg::KIND_ESTIMATE) begin
                        r_state <= S_WALK;
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_zeros <= '0;
                    end
                end
                S_WALK: begin
                    // Read data is registered and arrives in the cycle after its address.
                    if (r_cnt != '0) begin
                        r_sum <= r_sum + term;
                        if (walk_rank == '0) begin
                            r_zeros <= r_zeros + 1'b1;
                        end
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == (BB+1)'(NB)) begin
                        r_state <= S_DIV_GO;
                    end
                end
                S_DIV_GO: begin
                    r_k     <= k_calc;
                    r_y     <= 32'(r_zeros) << (5'd30 - 5'(k_calc));
                    r_small <= (cmp_rhs >= cmp_lhs) && (r_zeros != '0);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_LOG;
                        r_cnt   <= '0;
                    end
                end
                S_LOG: begin
                    if (y_sq[31]) begin
                        r_y <= {1'b0, y_sq[31:1]};
                    end else begin
                        r_y <= y_sq;
                    end
                    r_frac <= {r_frac[hls_pkg::FRAC_W-2:0], y_sq[31]};
                    r_raw  <= raw_sat;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == (BB+1)'(hls_pkg::FRAC_W - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= ln_arg * hls_pkg::LOG_W'(hls_pkg::LN2_Q30);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_vld || o_result.ready) begin
                        r_out_vld   <= 1'b1;
                        r_out_est   <= r_small ? small_est : r_raw;
                        r_out_small <= r_small;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid            = r_out_vld;
    assign o_result.estimate         = r_out_est;
    assign o_result.small_range_used = r_out_small;
endmodule
`default_nettype wire

// ----- hw/rtl/hls_checker.sv -----
// Port-level checks for the HyperLogLog sketch, bound to the top level.
// Depends on hls_pkg for the item kind codes and port widths.
`default_nettype none
module hls_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       i_in_ready,
    input wire logic [hls_pkg::KIND_W-1:0] i_in_kind,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [hls_pkg::EST_W-1:0]  i_out_est
);
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_est))
        else $error("stalled result beat changed");

    a_est_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_kind == hls_pkg::KIND_ESTIMATE |=> !i_in_ready)
        else $error("input not blocked during estimate");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_kind != hls_pkg::KIND_ESTIMATE && !i_out_valid
        |=> !i_out_valid)
        else $error("result beat without estimate request");
endmodule

bind hyperloglog_sketch hls_checker u_hls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_kind   (i_item.kind),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_est   (o_result.estimate)
);
`default_nettype wire
